// ----- sv/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
`default_nettype none

package spq_pkg;

	// queue geometry and field widths
	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;
	localparam int PRI_W = 16;
	localparam int OCC_W = 5;

	// operation codes
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// one stored entry
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic signed [PRI_W-1:0] prio;
	} entry_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/spq_cell.sv -----
// one slot of the sorted chain: holds an entry and shifts toward either neighbor
`default_nettype none

module spq_cell (
	input  wire                      clk,
	input  wire spq_pkg::cell_ctrl_t ctrl,
	input  wire                      occ,
	input  wire spq_pkg::entry_t     new_entry,
	input  wire spq_pkg::entry_t     left_entry,
	input  wire                      left_keep,
	input  wire spq_pkg::entry_t     right_entry,
	output spq_pkg::entry_t          entry,
	output logic                     keep
);

	spq_pkg::entry_t entry_q;
	spq_pkg::entry_t entry_d;

	// an occupied slot with a strictly smaller priority stays in place on insert
	assign keep = occ && (entry_q.prio < new_entry.prio);

	// next entry: hold, take the new item, or shift from a neighbor
	always_comb begin
		entry_d = entry_q;
		if (ctrl.ins) begin
			if (keep) begin
				entry_d = entry_q;
			end else if (left_keep) begin
				entry_d = new_entry;
			end else begin
				entry_d = left_entry;
			end
		end else if (ctrl.rem) begin
			entry_d = right_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

// ----- sv/sorted_priority_queue.sv -----
// top level of the sorted priority queue built as a chain of slot cells
`default_nettype none

// Bounded priority queue of (value, priority) pairs, smallest priority at the head.
// Command channel: an item (kind, value, priority_req) is taken at a rising edge
// with start high and busy low. kind selects insert or remove of the head entry.
// Result channel: exactly one result per item, shown for one cycle with done high,
// in the cycle right after the item is taken. status flags a remove on an empty
// queue or an insert into a full queue; both leave the queue unchanged. The head
// entry, head_valid and occupancy describe the queue after the item.
// Throughput: one item per cycle; busy is always low. Every slot compares the new
// priority against its own and shifts in the same cycle, so the handling of an item
// does not grow with the depth. Equal priorities place the newer entry first.
// Reset clears the entry count and the result strobe; slot contents are not
// cleared and are never shown. The receiver cannot stall, so results are
// presented once and must be taken as they appear.

module sorted_priority_queue (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire                                 kind,
	input  wire signed [spq_pkg::VAL_W-1:0]     value,
	input  wire signed [spq_pkg::PRI_W-1:0]     priority_req,
	output logic                                done,
	output logic       [1:0]                    status,
	output logic signed [spq_pkg::VAL_W-1:0]    head_value,
	output logic signed [spq_pkg::PRI_W-1:0]    head_priority,
	output logic                                head_valid,
	output logic       [spq_pkg::OCC_W-1:0]     occupancy
);

	logic                          accept;
	logic                          is_full;
	logic                          is_empty;
	spq_pkg::cell_ctrl_t           ctrl;
	spq_pkg::status_t              status_d;
	spq_pkg::status_t              status_q;
	logic                          done_q;
	logic [spq_pkg::CNT_W-1:0]     count_q;
	spq_pkg::entry_t               new_entry;
	spq_pkg::entry_t               cell_entry [spq_pkg::DEPTH];
	logic                          cell_keep  [spq_pkg::DEPTH];

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign is_full  = (count_q == spq_pkg::CNT_W'(spq_pkg::DEPTH));
	assign is_empty = (count_q == '0);

	assign new_entry.value = value;
	assign new_entry.prio  = priority_req;

	// decode the item into a chain command and a status
	always_comb begin
		ctrl.ins = 1'b0;
		ctrl.rem = 1'b0;
		status_d = spq_pkg::ST_DONE;
		if (kind == spq_pkg::KIND_INSERT) begin
			if (is_full) begin
				status_d = spq_pkg::ST_FULL;
			end else begin
				ctrl.ins = accept;
			end
		end else begin
			if (is_empty) begin
				status_d = spq_pkg::ST_EMPTY;
			end else begin
				ctrl.rem = accept;
			end
		end
	end

	// chain of slots, head at index zero
	for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occ         (spq_pkg::CNT_W'(i) < count_q),
			.new_entry   (new_entry),
			.left_entry  ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
			.left_keep   ((i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i - 1]),
			.right_entry ((i == spq_pkg::DEPTH - 1) ? cell_entry[i]
				: cell_entry[(i == spq_pkg::DEPTH - 1) ? i : i + 1]),
			.entry       (cell_entry[i]),
			.keep        (cell_keep[i])
		);
	end

	// entry count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (ctrl.ins) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.rem) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// status travels with the strobe
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
		end
	end

	// result ports read the updated chain head
	assign done          = done_q;
	assign status        = status_q;
	assign head_valid    = !is_empty;
	assign head_value    = is_empty ? '0 : cell_entry[0].value;
	assign head_priority = is_empty ? '0 : cell_entry[0].prio;
	assign occupancy     = spq_pkg::OCC_W'(count_q);

	// count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
		else $error("entry count above depth");

	// every accepted item yields a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("missing result after accepted item");

	// a full flag is only reported when the queue is full
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q == spq_pkg::ST_FULL) |->
		(count_q == spq_pkg::CNT_W'(spq_pkg::DEPTH)))
		else $error("full status with room left");

	// the two front slots stay in priority order
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= spq_pkg::CNT_W'(2)) |-> (cell_entry[0].prio <= cell_entry[1].prio))
		else $error("head slots out of order");

endmodule

`default_nettype wire
